FILE: sv/macd_pkg.sv
// Shared types and constants for the MACD crossover detector.
// Used by macd_step_unit and macd_crossover_detector; no dependencies.
package macd_pkg;

  localparam int PRICE_W    = 32;
  localparam int ALPHA_W    = 16;
  localparam int AVG_W      = 48;  // unsigned Q16.32 price averages
  localparam int SIG_W      = 49;  // signed Q16.32 MACD and signal average
  localparam int DIFF_W     = 50;  // signed difference fed to the step unit
  localparam int STEP_W     = 51;  // signed weighted step
  localparam int HALF_W     = 25;  // split point of the difference
  localparam int PROD_W     = HALF_W + 1 + ALPHA_W + 1;
  localparam int SUM_W      = PROD_W + HALF_W;
  localparam int FRAC_SHIFT = 16;
  localparam int OUT_W      = 33;
  localparam int ADDR_W     = 4;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 72;

  localparam logic [ALPHA_W-1:0] FAST_ALPHA_RST   = 16'd10082;
  localparam logic [ALPHA_W-1:0] SLOW_ALPHA_RST   = 16'd4855;
  localparam logic [ALPHA_W-1:0] SIGNAL_ALPHA_RST = 16'd13107;

  localparam logic [1:0] REG_FAST_ALPHA   = 2'd0;
  localparam logic [1:0] REG_SLOW_ALPHA   = 2'd1;
  localparam logic [1:0] REG_SIGNAL_ALPHA = 2'd2;

  localparam logic [1:0] REL_EQUAL = 2'd0;
  localparam logic [1:0] REL_BELOW = 2'd1;
  localparam logic [1:0] REL_ABOVE = 2'd2;

  localparam logic [1:0] TRADE_NONE = 2'd0;
  localparam logic [1:0] TRADE_BUY  = 2'd1;
  localparam logic [1:0] TRADE_SELL = 2'd2;

  typedef struct packed {
    logic               start;
    logic [ALPHA_W-1:0] alpha;
  } step_req_t;

endpackage

FILE: sv/macd_step_unit.sv
// Shared EMA step unit: floor(d * alpha / 2^16) through one 26x17 multiplier,
// two partial products in phases LO and HI, summed in phase SUM. Depends on macd_pkg.
module macd_step_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  macd_pkg::step_req_t                 req,
  input  logic signed [macd_pkg::DIFF_W-1:0]  d,
  output logic signed [macd_pkg::STEP_W-1:0]  step,
  output logic                                done
);
  import macd_pkg::*;

  localparam logic [1:0] P_IDLE = 2'd0;
  localparam logic [1:0] P_LO   = 2'd1;
  localparam logic [1:0] P_HI   = 2'd2;
  localparam logic [1:0] P_SUM  = 2'd3;

  logic [1:0]                phase_r, phase_nxt;
  logic signed [DIFF_W-1:0]  d_r;
  logic [ALPHA_W-1:0]        a_r;
  logic signed [PROD_W-1:0]  prod_r, lo_r;
  logic signed [STEP_W-1:0]  step_r, step_nxt;
  logic                      done_r;
  logic signed [HALF_W:0]    mul_a;
  logic signed [ALPHA_W:0]   mul_b;
  logic signed [PROD_W-1:0]  mul_p;
  logic signed [SUM_W-1:0]   full;
  logic signed [SUM_W-1:0]   shifted;

  // low half unsigned, high half carries the sign
  assign mul_a = (phase_r == P_LO) ? $signed({1'b0, d_r[HALF_W-1:0]})
                                   : $signed({d_r[DIFF_W-1], d_r[DIFF_W-1:HALF_W]});
  assign mul_b = $signed({1'b0, a_r});
  assign mul_p = mul_a * mul_b;

  assign full     = (SUM_W'(prod_r) <<< HALF_W) + SUM_W'(lo_r);
  assign shifted  = full >>> FRAC_SHIFT;
  assign step_nxt = shifted[STEP_W-1:0];

  always_comb begin
    case (phase_r)
      P_IDLE:  phase_nxt = req.start ? P_LO : P_IDLE;
      P_LO:    phase_nxt = P_HI;
      P_HI:    phase_nxt = P_SUM;
      P_SUM:   phase_nxt = P_IDLE;
      default: phase_nxt = P_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= P_IDLE;
      done_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      done_r  <= (phase_r == P_SUM);
    end
  end

  always_ff @(posedge clk) begin
    if (phase_r == P_IDLE && req.start) begin
      d_r <= d;
      a_r <= req.alpha;
    end
    if (phase_r == P_LO || phase_r == P_HI) begin
      prod_r <= mul_p;
    end
    if (phase_r == P_HI) begin
      lo_r <= prod_r;
    end
    if (phase_r == P_SUM) begin
      step_r <= step_nxt;
    end
  end

  assign step = step_r;
  assign done = done_r;

  a_done_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(req.start, 4))
    else $error("step done without a start four cycles before");

  a_start_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> phase_r == P_IDLE)
    else $error("step start while the unit is busy");

  a_sum_then_done: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == P_SUM) |=> done_r && phase_r == P_IDLE)
    else $error("sum phase did not produce done");

endmodule

FILE: sv/macd_crossover_detector.sv
// MACD crossover detector top level: sequencer, averages, APB registers.
// Depends on macd_pkg and macd_step_unit.
//
// Usage: one price beat (in_tdata = unsigned Q16.16 price, in_tuser =
// first_sample) yields one result beat carrying MACD, the signal line and a
// trade flag (none, buy or sell crossover). Fast, slow and signal EMAs run
// through one shared multiplier, two partial products per update.
// A seeding beat (first_sample high, or the first beat after reset) loads
// the price averages and goes straight to the result state, then back to
// idle for the next beat. Any other beat runs the fast and slow EMA updates
// on the multiplier, forms MACD, runs the signal EMA update and the compare,
// then loads its result and returns to idle for the next beat.
// in_tready is low while a beat is in work. The result sits in an output
// register; if the receiver stalls, the next beat still goes through the
// averages and holds at its last step until the register frees.
// Reset (rst_n low, synchronous) clears the averages, returns the weights
// to 12/26/9 defaults and drops out_tvalid. The APB port writes the three
// Q0.16 weights at addresses 0, 4 and 8; write only while idle.
module macd_crossover_detector (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // APB configuration
  input  logic                                 cfg_psel,
  input  logic                                 cfg_penable,
  input  logic                                 cfg_pwrite,
  input  logic [macd_pkg::ADDR_W-1:0]          cfg_paddr,
  input  logic [31:0]                          cfg_pwdata,
  output logic [31:0]                          cfg_prdata,
  output logic                                 cfg_pready,
  // input stream
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [macd_pkg::IN_DATA_W-1:0]       in_tdata,  // [31:0] price
  input  logic                                 in_tuser,  // [0] first_sample
  // result stream
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // [32:0] macd_value, [65:33] signal_line, [67:66] trade, [71:68] zero
  output logic [macd_pkg::OUT_DATA_W-1:0]      out_tdata
);
  import macd_pkg::*;

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_F_GO   = 4'd1;
  localparam logic [3:0] ST_F_WAIT = 4'd2;
  localparam logic [3:0] ST_S_GO   = 4'd3;
  localparam logic [3:0] ST_S_WAIT = 4'd4;
  localparam logic [3:0] ST_MACD   = 4'd5;
  localparam logic [3:0] ST_G_GO   = 4'd6;
  localparam logic [3:0] ST_G_WAIT = 4'd7;
  localparam logic [3:0] ST_CMP    = 4'd8;
  localparam logic [3:0] ST_DONE   = 4'd9;

  logic [3:0]               state_r, state_nxt;
  logic [ALPHA_W-1:0]       fast_alpha_r, slow_alpha_r, signal_alpha_r;
  logic [PRICE_W-1:0]       price_r;
  logic [AVG_W-1:0]         fast_r, slow_r;
  logic signed [SIG_W-1:0]  sig_r, macd_r;
  logic [1:0]               rel_r, rel_nxt, trade_r, trade_nxt;
  logic                     started_r, seed_r;
  logic                     out_valid_r;
  logic [OUT_DATA_W-1:0]    out_data_r;

  logic                     in_accept, seed_now, out_load, cfg_write;
  step_req_t                step_req;
  logic signed [DIFF_W-1:0] unit_d, d_fast, d_slow, d_sig;
  logic signed [STEP_W-1:0] unit_step;
  logic                     unit_done;
  logic signed [SIG_W-1:0]  macd_nxt;

  // ---------------- configuration port ----------------
  assign cfg_pready = 1'b1;
  assign cfg_write  = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fast_alpha_r   <= FAST_ALPHA_RST;
      slow_alpha_r   <= SLOW_ALPHA_RST;
      signal_alpha_r <= SIGNAL_ALPHA_RST;
    end else if (cfg_write) begin
      case (cfg_paddr[3:2])
        REG_FAST_ALPHA:   fast_alpha_r   <= cfg_pwdata[ALPHA_W-1:0];
        REG_SLOW_ALPHA:   slow_alpha_r   <= cfg_pwdata[ALPHA_W-1:0];
        REG_SIGNAL_ALPHA: signal_alpha_r <= cfg_pwdata[ALPHA_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      REG_FAST_ALPHA:   cfg_prdata = {16'h0, fast_alpha_r};
      REG_SLOW_ALPHA:   cfg_prdata = {16'h0, slow_alpha_r};
      REG_SIGNAL_ALPHA: cfg_prdata = {16'h0, signal_alpha_r};
      default:          cfg_prdata = 32'h0;
    endcase
  end

  // ---------------- shared step unit ----------------
  assign d_fast = $signed({2'b00, price_r, 16'h0}) - $signed({2'b00, fast_r});
  assign d_slow = $signed({2'b00, price_r, 16'h0}) - $signed({2'b00, slow_r});
  assign d_sig  = $signed({macd_r[SIG_W-1], macd_r}) - $signed({sig_r[SIG_W-1], sig_r});

  always_comb begin
    step_req.start = (state_r == ST_F_GO) || (state_r == ST_S_GO) || (state_r == ST_G_GO);
    case (state_r)
      ST_F_GO: begin
        step_req.alpha = fast_alpha_r;
        unit_d         = d_fast;
      end
      ST_S_GO: begin
        step_req.alpha = slow_alpha_r;
        unit_d         = d_slow;
      end
      default: begin
        step_req.alpha = signal_alpha_r;
        unit_d         = d_sig;
      end
    endcase
  end

  macd_step_unit u_step (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (step_req),
    .d     (unit_d),
    .step  (unit_step),
    .done  (unit_done)
  );

  // ---------------- sequencer ----------------
  assign in_tready = (state_r == ST_IDLE);
  assign in_accept = in_tvalid & in_tready;
  assign seed_now  = in_tuser | ~started_r;
  assign out_load  = (state_r == ST_DONE) && (!out_valid_r || out_tready);

  always_comb begin
    case (state_r)
      ST_IDLE:   state_nxt = !in_accept ? ST_IDLE : (seed_now ? ST_DONE : ST_F_GO);
      ST_F_GO:   state_nxt = ST_F_WAIT;
      ST_F_WAIT: state_nxt = unit_done ? ST_S_GO : ST_F_WAIT;
      ST_S_GO:   state_nxt = ST_S_WAIT;
      ST_S_WAIT: state_nxt = unit_done ? ST_MACD : ST_S_WAIT;
      ST_MACD:   state_nxt = ST_G_GO;
      ST_G_GO:   state_nxt = ST_G_WAIT;
      ST_G_WAIT: state_nxt = unit_done ? ST_CMP : ST_G_WAIT;
      ST_CMP:    state_nxt = ST_DONE;
      ST_DONE:   state_nxt = out_load ? ST_IDLE : ST_DONE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  assign macd_nxt = $signed({1'b0, fast_r}) - $signed({1'b0, slow_r});

  always_comb begin
    if (macd_r < sig_r) begin
      rel_nxt = REL_BELOW;
    end else if (macd_r > sig_r) begin
      rel_nxt = REL_ABOVE;
    end else begin
      rel_nxt = REL_EQUAL;
    end
    if (rel_r == REL_BELOW && rel_nxt == REL_ABOVE) begin
      trade_nxt = TRADE_BUY;
    end else if (rel_r == REL_ABOVE && rel_nxt == REL_BELOW) begin
      trade_nxt = TRADE_SELL;
    end else begin
      trade_nxt = TRADE_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fast_r      <= '0;
      slow_r      <= '0;
      sig_r       <= '0;
      macd_r      <= '0;
      rel_r       <= REL_EQUAL;
      trade_r     <= TRADE_NONE;
      started_r   <= 1'b0;
      seed_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_accept) begin
        seed_r <= seed_now;
        if (seed_now) begin
          // seed: both price averages take the price, signal restarts at zero
          fast_r    <= {in_tdata, 16'h0};
          slow_r    <= {in_tdata, 16'h0};
          sig_r     <= '0;
          macd_r    <= '0;
          rel_r     <= REL_EQUAL;
          trade_r   <= TRADE_NONE;
          started_r <= 1'b1;
        end
      end
      if (state_r == ST_F_WAIT && unit_done) begin
        fast_r <= fast_r + unit_step[AVG_W-1:0];
      end
      if (state_r == ST_S_WAIT && unit_done) begin
        slow_r <= slow_r + unit_step[AVG_W-1:0];
      end
      if (state_r == ST_MACD) begin
        macd_r <= macd_nxt;
      end
      if (state_r == ST_G_WAIT && unit_done) begin
        sig_r <= sig_r + unit_step[SIG_W-1:0];
      end
      if (state_r == ST_CMP) begin
        rel_r   <= rel_nxt;
        trade_r <= trade_nxt;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      price_r <= in_tdata;
    end
    if (out_load) begin
      // drop the low 16 fraction bits; the bit slice is the floor
      out_data_r <= {4'h0, trade_r, sig_r[SIG_W-1:FRAC_SHIFT], macd_r[SIG_W-1:FRAC_SHIFT]};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_buy_ends_above: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && trade_r == TRADE_BUY) |-> rel_r == REL_ABOVE)
    else $error("buy flagged without MACD above signal");

  a_sell_ends_below: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && trade_r == TRADE_SELL) |-> rel_r == REL_BELOW)
    else $error("sell flagged without MACD below signal");

  a_seed_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && seed_r) |-> macd_r == '0 && sig_r == '0 && trade_r == TRADE_NONE)
    else $error("seeding beat left MACD, signal or trade set");

  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    unit_done |-> (state_r == ST_F_WAIT || state_r == ST_S_WAIT || state_r == ST_G_WAIT))
    else $error("step result arrived outside a wait state");

endmodule
